### rtl/fll_pkg.sv
package fll_pkg;

    localparam int KEYWORD_CHARS = 6;
    localparam int MAX_FRACTION_DIGITS = 9;
    localparam int IDX_W = $clog2(KEYWORD_CHARS + 1);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_IDENT  = 3'd1,
        PH_INT    = 3'd2,
        PH_FRAC   = 3'd3,
        PH_STRING = 3'd4,
        PH_ESCAPE = 3'd5,
        PH_OPER   = 3'd6
    } phase_t;

    localparam logic [5:0] K_INVALID = 6'd0;
    localparam logic [5:0] K_ID = 6'd1;
    localparam logic [5:0] K_KW_BASE = 6'd2;
    localparam logic [5:0] K_LIT_INT = 6'd12;
    localparam logic [5:0] K_LIT_FLOAT = 6'd13;
    localparam logic [5:0] K_LIT_STRING = 6'd14;
    localparam logic [5:0] K_STRCHAR = 6'd39;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] text_length;
        logic [15:0] line_index;
        logic [31:0] int_value;
        logic [29:0] frac_value;
        logic [3:0]  frac_digits;
        logic [7:0]  char_value;
        logic        last_of_run;
    } token_t;

    localparam token_t TOKEN_ZERO = '0;

    typedef logic [7:0] chars_t [KEYWORD_CHARS];

    function automatic logic [5:0] single_char_kind(input logic [7:0] c);
        case (c)
            8'h2B: return 6'd15;
            8'h2D: return 6'd16;
            8'h2A: return 6'd17;
            8'h2F: return 6'd18;
            8'h23: return 6'd19;
            8'h3A: return 6'd20;
            8'h28: return 6'd21;
            8'h29: return 6'd22;
            8'h5B: return 6'd23;
            8'h5D: return 6'd24;
            8'h7B: return 6'd25;
            8'h7D: return 6'd26;
            8'h2C: return 6'd28;
            8'h3B: return 6'd29;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] oper_single(input logic [7:0] p);
        case (p)
            8'h3D: return 6'd27;
            8'h3E: return 6'd30;
            8'h3C: return 6'd31;
            8'h21: return 6'd32;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] oper_double(input logic [7:0] p);
        case (p)
            8'h3D: return 6'd33;
            8'h3E: return 6'd34;
            8'h3C: return 6'd35;
            8'h21: return 6'd36;
            8'h26: return 6'd37;
            default: return 6'd38;
        endcase
    endfunction

endpackage

### rtl/formula_language_lexer.sv
// Streaming lexer for a small formula language.
// The input channel (s_valid/s_ready) takes one source byte per word with
// s_mode low, or an end-of-text word with s_mode high that flushes any held
// token and returns the lexer to its reset state.
// The result channel (m_valid/m_ready) carries tokens and decoded string
// characters; m_last_of_run marks the final result of each input word.
// Each input word is lexed in the cycle it is accepted, and its results
// appear in the result register on the next cycle.
// A word causes zero, one or two results. One word is accepted per cycle
// while every word causes at most one result and the receiver keeps up; a word
// causing two results holds the input off while the second result is sent.
// s_ready falls while the one-entry overflow register is full, or while the
// result register is full and the receiver stalls, until space is free again.
// After reset (aresetn low, synchronous) the lexer is idle at position
// zero, line zero, with no result pending.
module formula_language_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_text_length,
    output logic [15:0] m_line_index,
    output logic signed [31:0] m_int_value,
    output logic [29:0] m_frac_value,
    output logic [3:0]  m_frac_digits,
    output logic [7:0]  m_char_value,
    output logic        m_last_of_run
);
    import fll_pkg::*;

    phase_t phase_reg, phase_next;
    logic [7:0] pend_reg, pend_next;
    logic [15:0] pos_reg, pos_next, begin_reg, begin_next, line_reg, line_next;
    chars_t chars_reg, chars_next;
    logic [IDX_W-1:0] ilen_reg, ilen_next;
    logic over_reg, over_next;
    logic [31:0] iacc_reg, iacc_next;
    logic [29:0] facc_reg, facc_next;
    logic [3:0] fcnt_reg, fcnt_next;

    token_t out_reg, out_next, ovf_reg, ovf_next;
    logic out_v_reg, out_v_next, ovf_v_reg, ovf_v_next;

    token_t r0, r1;
    logic [1:0] n_res;
    logic [5:0] kw_kind;
    logic accept;

    fll_keyword u_kw (.chars(chars_reg), .len(ilen_reg), .overlong(over_reg),
                      .kind(kw_kind));

    assign s_ready = !ovf_v_reg && (!out_v_reg || m_ready);
    assign accept = s_valid && s_ready;

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction
    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [3:0] d;
        logic do_idle, do_flush;
        token_t t;
        logic [15:0] span, esc;
        token_t res [2];
        logic [1:0] n;
        logic [7:0] want;

        c = s_char_code;
        d = 4'(c - 8'h30);
        span = pos_reg - begin_reg;
        esc = pos_reg - 16'd1;
        phase_next = phase_reg; pend_next = pend_reg; pos_next = pos_reg;
        begin_next = begin_reg; line_next = line_reg; chars_next = chars_reg;
        ilen_next = ilen_reg; over_next = over_reg; iacc_next = iacc_reg;
        facc_next = facc_reg; fcnt_next = fcnt_reg;
        res[0] = TOKEN_ZERO; res[1] = TOKEN_ZERO; n = 2'd0;
        do_idle = 1'b0; do_flush = 1'b0;
        want = 8'h3D;
        t = TOKEN_ZERO;

        if (s_mode) begin
            if (phase_reg == PH_STRING || phase_reg == PH_ESCAPE) begin
                t.token_kind = K_INVALID; t.start_offset = begin_reg;
                t.text_length = span; t.line_index = line_reg;
                res[0] = t; n = 2'd1;
            end else begin
                do_flush = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_IDENT: begin
                    if (letter_char(c) || digit_char(c) || c == 8'h5F) begin
                        if (ilen_reg < IDX_W'(KEYWORD_CHARS)) begin
                            chars_next[ilen_reg[IDX_W-1:0]] = c;
                            ilen_next = ilen_reg + IDX_W'(1);
                        end else begin
                            over_next = 1'b1;
                        end
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                PH_INT: begin
                    if (digit_char(c)) begin
                        iacc_next = (iacc_reg << 3) + (iacc_reg << 1) + 32'(d);
                    end else if (c == 8'h2E) begin
                        phase_next = PH_FRAC;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                PH_FRAC: begin
                    if (digit_char(c)) begin
                        if (fcnt_reg < 4'(MAX_FRACTION_DIGITS)) begin
                            facc_next = (facc_reg << 3) + (facc_reg << 1) + 30'(d);
                            fcnt_next = fcnt_reg + 4'd1;
                        end
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                PH_OPER: begin
                    if (pend_reg == 8'h26 || pend_reg == 8'h7C) want = pend_reg;
                    if (c == want) begin
                        t.token_kind = oper_double(pend_reg);
                        t.start_offset = begin_reg; t.text_length = 16'd2;
                        t.line_index = line_reg;
                        res[0] = t; n = 2'd1;
                        phase_next = PH_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                PH_STRING: begin
                    if (c == 8'h22) begin
                        t.token_kind = K_LIT_STRING; t.start_offset = begin_reg;
                        t.text_length = span + 16'd1; t.line_index = line_reg;
                        res[0] = t; n = 2'd1;
                        phase_next = PH_IDLE;
                    end else if (c == 8'h5C) begin
                        phase_next = PH_ESCAPE;
                    end else begin
                        if (c == 8'h0A) line_next = line_reg + 16'd1;
                        t.token_kind = K_STRCHAR; t.start_offset = pos_reg;
                        t.text_length = 16'd1; t.line_index = line_next;
                        t.char_value = c;
                        res[0] = t; n = 2'd1;
                    end
                end
                PH_ESCAPE: begin
                    phase_next = PH_STRING;
                    t.token_kind = K_STRCHAR; t.start_offset = esc;
                    t.text_length = 16'd2; t.line_index = line_reg;
                    case (c)
                        8'h5C, 8'h22, 8'h27: begin
                            t.char_value = c; res[0] = t; n = 2'd1;
                        end
                        8'h6E: begin
                            t.char_value = 8'h0A; res[0] = t; n = 2'd1;
                        end
                        8'h72: begin
                            t.char_value = 8'h0D; res[0] = t; n = 2'd1;
                        end
                        8'h0A: line_next = line_reg + 16'd1;
                        default: begin
                            t.char_value = 8'h5C; res[0] = t;
                            t.char_value = c; res[1] = t; n = 2'd2;
                        end
                    endcase
                end
                default: do_idle = 1'b1;
            endcase
        end

        if (do_flush) begin
            t = TOKEN_ZERO;
            t.start_offset = begin_reg; t.text_length = span;
            t.line_index = line_reg;
            case (phase_reg)
                PH_IDENT: begin t.token_kind = kw_kind; res[0] = t; n = 2'd1; end
                PH_INT: begin
                    t.token_kind = K_LIT_INT; t.int_value = iacc_reg;
                    res[0] = t; n = 2'd1;
                end
                PH_FRAC: begin
                    t.token_kind = K_LIT_FLOAT; t.int_value = iacc_reg;
                    t.frac_value = facc_reg; t.frac_digits = fcnt_reg;
                    res[0] = t; n = 2'd1;
                end
                PH_OPER: begin
                    t.token_kind = oper_single(pend_reg); t.text_length = 16'd1;
                    res[0] = t; n = 2'd1;
                end
                default: ;
            endcase
            phase_next = PH_IDLE;
        end

        if (do_idle) begin
            t = TOKEN_ZERO;
            if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
            end else if (c == 8'h0A) begin
                line_next = line_reg + 16'd1;
            end else begin
                begin_next = pos_reg;
                if (letter_char(c) || c == 8'h5F) begin
                    phase_next = PH_IDENT; chars_next[0] = c;
                    ilen_next = IDX_W'(1); over_next = 1'b0;
                end else if (digit_char(c)) begin
                    phase_next = PH_INT; iacc_next = 32'(d);
                    facc_next = '0; fcnt_next = '0;
                end else if (c == 8'h22) begin
                    phase_next = PH_STRING;
                end else if (c == 8'h3D || c == 8'h3E || c == 8'h3C || c == 8'h21
                             || c == 8'h26 || c == 8'h7C) begin
                    phase_next = PH_OPER; pend_next = c;
                end else begin
                    t.token_kind = single_char_kind(c); t.start_offset = pos_reg;
                    t.text_length = 16'd1; t.line_index = line_next;
                    res[n[0]] = t; n = n + 2'd1;
                end
            end
        end

        if (s_mode) begin
            phase_next = PH_IDLE; pend_next = '0; pos_next = '0; begin_next = '0;
            line_next = '0; ilen_next = '0; over_next = 1'b0; iacc_next = '0;
            facc_next = '0; fcnt_next = '0;
        end else begin
            pos_next = pos_reg + 16'd1;
        end

        if (n == 2'd1) res[0].last_of_run = 1'b1;
        if (n == 2'd2) res[1].last_of_run = 1'b1;
        r0 = res[0]; r1 = res[1]; n_res = n;
    end

    always_comb begin
        logic take;
        out_next = out_reg; out_v_next = out_v_reg;
        ovf_next = ovf_reg; ovf_v_next = ovf_v_reg;
        take = out_v_reg && m_ready;
        if (take) begin
            out_v_next = ovf_v_reg; out_next = ovf_reg; ovf_v_next = 1'b0;
        end
        if (accept && n_res != 2'd0) begin
            out_next = r0; out_v_next = 1'b1;
            if (n_res == 2'd2) begin
                ovf_next = r1; ovf_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; pend_reg <= '0; pos_reg <= '0; begin_reg <= '0;
            line_reg <= '0; ilen_reg <= '0; over_reg <= 1'b0; iacc_reg <= '0;
            facc_reg <= '0; fcnt_reg <= '0; out_v_reg <= 1'b0; ovf_v_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next; pend_reg <= pend_next; pos_reg <= pos_next;
                begin_reg <= begin_next; line_reg <= line_next; ilen_reg <= ilen_next;
                over_reg <= over_next; iacc_reg <= iacc_next; facc_reg <= facc_next;
                fcnt_reg <= fcnt_next;
            end
            out_v_reg <= out_v_next; ovf_v_reg <= ovf_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) chars_reg <= chars_next;
        out_reg <= out_next;
        ovf_reg <= ovf_next;
    end

    assign m_valid = out_v_reg;
    assign m_token_kind = out_reg.token_kind;
    assign m_start_offset = out_reg.start_offset;
    assign m_text_length = out_reg.text_length;
    assign m_line_index = out_reg.line_index;
    assign m_int_value = signed'(out_reg.int_value);
    assign m_frac_value = out_reg.frac_value;
    assign m_frac_digits = out_reg.frac_digits;
    assign m_char_value = out_reg.char_value;
    assign m_last_of_run = out_reg.last_of_run;
endmodule

### rtl/fll_keyword.sv
module fll_keyword (
    input  fll_pkg::chars_t               chars,
    input  logic [fll_pkg::IDX_W-1:0]     len,
    input  logic                          overlong,
    output logic [5:0]                    kind
);
    import fll_pkg::*;

    function automatic logic match(input chars_t ch, input logic [IDX_W-1:0] n,
                                   input logic [47:0] word, input int wl);
        logic ok;
        ok = (n == IDX_W'(wl));
        for (int i = 0; i < 6; i++) begin
            if (i < wl && i < KEYWORD_CHARS) begin
                ok = ok && (ch[i] == word[47-8*i -: 8]);
            end
        end
        if (wl > KEYWORD_CHARS) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb begin
        kind = K_ID;
        if (!overlong) begin
            if (match(chars, len, {"if", 32'd0}, 2)) kind = K_KW_BASE + 6'd0;
            else if (match(chars, len, {"else", 16'd0}, 4)) kind = K_KW_BASE + 6'd1;
            else if (match(chars, len, "return", 6)) kind = K_KW_BASE + 6'd2;
            else if (match(chars, len, {"let", 24'd0}, 3)) kind = K_KW_BASE + 6'd3;
            else if (match(chars, len, {"while", 8'd0}, 5)) kind = K_KW_BASE + 6'd4;
            else if (match(chars, len, {"for", 24'd0}, 3)) kind = K_KW_BASE + 6'd5;
            else if (match(chars, len, {"int", 24'd0}, 3)) kind = K_KW_BASE + 6'd6;
            else if (match(chars, len, {"float", 8'd0}, 5)) kind = K_KW_BASE + 6'd7;
            else if (match(chars, len, "string", 6)) kind = K_KW_BASE + 6'd8;
            else if (match(chars, len, {"cell", 16'd0}, 4)) kind = K_KW_BASE + 6'd9;
        end
    end
endmodule

### rtl/fll_checker.sv
module fll_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_token_kind,
    input logic [3:0]  m_frac_digits,
    input logic [29:0] m_frac_value
);
    import fll_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind))
        else $error("result word changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= K_STRCHAR)
        else $error("token kind out of range");

    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frac_digits <= 4'(MAX_FRACTION_DIGITS))
        else $error("too many fraction digits");

    a_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != K_LIT_FLOAT |-> m_frac_value == '0)
        else $error("fraction on non-decimal word");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input held off with no result waiting");
endmodule

bind formula_language_lexer fll_checker u_fll_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_token_kind(m_token_kind),
    .m_frac_digits(m_frac_digits), .m_frac_value(m_frac_value)
);
